FILE: rtl/bgm_pkg.sv
package bgm_pkg;

  localparam int unsigned PtW    = 13;
  localparam int unsigned RateW  = 11;
  localparam int unsigned MvW    = 16;
  localparam int unsigned TsW    = 32;
  localparam int unsigned PctW   = 7;
  localparam int unsigned BarsW  = 3;
  localparam int unsigned MinsW  = 22;
  localparam int unsigned RawW   = 16;
  localparam int unsigned SrcW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Divider: 64-bit dividend, 32-bit divisor, one quotient bit a cycle
  localparam int unsigned DivNW = 64;
  localparam int unsigned DivDW = 32;

  localparam logic [CfgIdxW-1:0] CfgPt0     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPt4     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNominal = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgEnable  = 3'd6;

  localparam logic [RateW-1:0] MaxRate        = 11'd2000;
  localparam logic [MvW:0]     RecoveryMargin = 17'd100;
  localparam logic [21:0]      MsPerHour      = 22'd3600000;

  typedef enum logic [2:0] {
    StIdle,
    StPct,
    StRate,
    StMins,
    StOut
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DivNW-1:0]     num;
    logic [DivDW-1:0]     den;
  } div_req_t;

endpackage

FILE: rtl/bgm_if.sv
interface bgm_in_if;
  logic                        valid;
  logic                        ready;
  logic [bgm_pkg::RawW-1:0]    raw_code;
  logic [bgm_pkg::MvW-1:0]     sample_mv;
  logic [bgm_pkg::SrcW-1:0]    source_id;
  logic [bgm_pkg::TsW-1:0]     now_ms;
  modport source (output valid, raw_code, sample_mv, source_id, now_ms, input ready);
  modport sink   (input valid, raw_code, sample_mv, source_id, now_ms, output ready);
endinterface

interface bgm_out_if;
  logic                        valid;
  logic                        ready;
  logic [bgm_pkg::PctW-1:0]    percent;
  logic [bgm_pkg::BarsW-1:0]   bars;
  logic                        low_flag;
  logic [bgm_pkg::RateW-1:0]   rate_out;
  logic [bgm_pkg::MinsW-1:0]   minutes_left;
  logic                        changed;
  modport source (output valid, percent, bars, low_flag, rate_out, minutes_left, changed,
                  input ready);
  modport sink   (input valid, percent, bars, low_flag, rate_out, minutes_left, changed,
                  output ready);
endinterface

interface bgm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bgm_pkg::CfgIdxW-1:0]    index;
  logic [bgm_pkg::CfgDataW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/battery_gauge_monitor.sv
// Flow: an accepted word passes through the percent, rate and minutes phases, each of which
// may run a division (start, 64 quotient bits, handoff), then moves into the output register.
// Throughput: one word at a time; the next input word is taken the cycle after the result
// word has moved into the output register.
// The shared bit-serial divider (one quotient bit per cycle) sets how long each word takes.
// Reset (rst_ni low, asynchronous): calibration 3500/3660/3720/3800/4000 mV, nominal 120 mV/h.
module battery_gauge_monitor #(
  parameter int unsigned LOW_CONFIRM    = 3,
  parameter int unsigned NORMAL_CONFIRM = 2,
  parameter int unsigned RATE_WINDOW_MS = 300000
) (
  input  logic clk_i,
  input  logic rst_ni,
  bgm_cfg_if.sink   cfg_i,
  bgm_in_if.sink    in_i,
  bgm_out_if.source out_o
);
  import bgm_pkg::*;

  localparam int unsigned CntW = 4; // confirm counts up to 15

  // configuration
  logic [PtW-1:0]   pt_q [5];
  logic [RateW-1:0] nominal_q;
  logic             enable_q;

  // gauge state
  logic             have_q, low_q;
  logic [CntW-1:0]  low_cnt_q, norm_cnt_q;
  logic [RawW-1:0]  last_raw_q;
  logic [PctW-1:0]  last_pct_q;
  logic [BarsW-1:0] last_bars_q;
  logic [SrcW-1:0]  last_src_q;
  logic [TsW-1:0]   win_ms_q;
  logic [MvW-1:0]   win_mv_q;
  logic [RateW-1:0] smooth_q;

  // captured word and working results
  logic [RawW-1:0]  raw_q;
  logic [MvW-1:0]   mv_q;
  logic [SrcW-1:0]  src_q;
  logic [TsW-1:0]   now_q;
  logic [PctW-1:0]  pct_q;
  logic [RateW-1:0] rate_q;
  logic             do_rate_q;

  state_e state_q, state_d;

  div_req_t         div_req;
  logic             div_done;
  logic [DivNW-1:0] div_quot;

  // output register
  logic             ovalid_q;
  logic [PctW-1:0]  o_pct_q;
  logic [BarsW-1:0] o_bars_q;
  logic             o_low_q, o_chg_q;
  logic [RateW-1:0] o_rate_q;
  logic [MinsW-1:0] o_mins_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle);

  wire in_acc  = in_i.valid && in_i.ready;
  wire out_free = !ovalid_q || out_o.ready;

  // segment search: narrow compares against the five points
  logic [2:0]       seg;
  logic             pct_direct;
  logic [PctW-1:0]  pct_fixed;
  logic [PtW-1:0]   seg_lo, seg_hi;
  logic [MvW-1:0]   seg_off, seg_span;
  always_comb begin
    seg = 3'd0;
    pct_direct = 1'b1;
    pct_fixed  = '0;
    if ({3'b0, pt_q[0]} >= mv_q) pct_fixed = '0;
    else if (mv_q >= {3'b0, pt_q[4]}) pct_fixed = PctW'(100);
    else begin
      if (mv_q <= {3'b0, pt_q[1]}) seg = 3'd0;
      else if (mv_q <= {3'b0, pt_q[2]}) seg = 3'd1;
      else if (mv_q <= {3'b0, pt_q[3]}) seg = 3'd2;
      else seg = 3'd3;
      pct_fixed = PctW'(({4'b0, seg} + 7'd1) * 7'd25);
      pct_direct = (pt_q[seg+3'd1] <= pt_q[seg]);
    end
    seg_lo = pt_q[seg];
    seg_hi = pt_q[seg+3'd1];
    seg_span = MvW'(seg_hi - seg_lo);
    seg_off  = (mv_q > {3'b0, seg_lo}) ? mv_q - {3'b0, seg_lo} : '0;
  end

  // rate window
  logic [TsW-1:0] elapsed;
  logic [RateW-1:0] base_rate;
  assign base_rate = (smooth_q == '0) ? nominal_q : smooth_q;
  assign elapsed   = now_q - win_ms_q;
  wire win_open  = (win_ms_q == '0);
  wire win_close = !win_open && (elapsed >= TsW'(RATE_WINDOW_MS));
  wire measure   = win_close && enable_q && (win_mv_q > mv_q) && (elapsed != '0);

  // smoothing with the measured rate
  logic [RateW+2:0] smooth_sum;
  logic [RateW-1:0] new_rate;
  always_comb begin
    smooth_sum = {2'b0, base_rate, 1'b0} + {3'b0, base_rate} + div_quot[RateW+2:0] + 14'd2;
    new_rate = base_rate;
    if (div_quot != '0 && div_quot <= DivNW'(MaxRate))
      new_rate = (base_rate != '0) ? smooth_sum[RateW+1:2] : div_quot[RateW-1:0];
  end

  // low filter and change detection
  logic             low_n;
  logic [CntW-1:0]  low_cnt_n, norm_cnt_n;
  logic [BarsW-1:0] bars_n;
  logic             chg_n;
  always_comb begin
    low_cnt_n  = low_cnt_q;
    norm_cnt_n = norm_cnt_q;
    if (low_q) begin
      if ({1'b0, mv_q} < {4'b0, pt_q[1]} + RecoveryMargin) begin
        norm_cnt_n = '0;
        low_n = 1'b1;
      end else begin
        low_cnt_n = '0;
        if (norm_cnt_q < CntW'(NORMAL_CONFIRM)) norm_cnt_n = norm_cnt_q + 1'b1;
        low_n = norm_cnt_n < CntW'(NORMAL_CONFIRM);
      end
    end else if (mv_q <= {3'b0, pt_q[1]}) begin
      norm_cnt_n = '0;
      if (low_cnt_q < CntW'(LOW_CONFIRM)) low_cnt_n = low_cnt_q + 1'b1;
      low_n = low_cnt_n >= CntW'(LOW_CONFIRM);
    end else begin
      low_cnt_n = '0;
      norm_cnt_n = '0;
      low_n = 1'b0;
    end
    // bar thresholds by compare, four at full
    if (pct_q >= PctW'(100))     bars_n = 3'd4;
    else if (pct_q >= PctW'(75)) bars_n = 3'd3;
    else if (pct_q >= PctW'(50)) bars_n = 3'd2;
    else if (pct_q >= PctW'(25)) bars_n = 3'd1;
    else                         bars_n = 3'd0;
    chg_n = !have_q || last_raw_q != raw_q || last_pct_q != pct_q ||
            last_bars_q != bars_n || low_q != low_n || last_src_q != src_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc) state_d = StPct;
      StPct:  if (pct_direct || div_done) state_d = StRate;
      StRate: if (!measure || div_done) state_d = StMins;
      StMins: if (rate_q == '0 || mv_q <= {3'b0, pt_q[0]} || div_done) state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // divider requests, at most one per phase
  logic started_q;
  always_comb begin
    div_req = '0;
    if (!started_q) begin
      case (state_q)
        StPct: if (!pct_direct) begin
          div_req.start = 1'b1;
          div_req.num = DivNW'(seg_off) * DivNW'(25) + DivNW'(seg_span >> 1);
          div_req.den = DivDW'(seg_span);
        end
        StRate: if (measure) begin
          div_req.start = 1'b1;
          div_req.num = DivNW'(win_mv_q - mv_q) * DivNW'(MsPerHour);
          div_req.den = elapsed;
        end
        StMins: if (rate_q != '0 && mv_q > {3'b0, pt_q[0]}) begin
          div_req.start = 1'b1;
          div_req.num = DivNW'(mv_q - {3'b0, pt_q[0]}) * DivNW'(60);
          div_req.den = DivDW'(rate_q);
        end
        default: ;
      endcase
    end
  end

  bgm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      started_q <= 1'b0;
      pt_q[0] <= 13'd3500; pt_q[1] <= 13'd3660; pt_q[2] <= 13'd3720;
      pt_q[3] <= 13'd3800; pt_q[4] <= 13'd4000;
      nominal_q <= 11'd120;
      enable_q  <= 1'b1;
      have_q <= 1'b0; low_q <= 1'b0;
      low_cnt_q <= '0; norm_cnt_q <= '0;
      last_raw_q <= '0; last_pct_q <= '0; last_bars_q <= '0; last_src_q <= '0;
      win_ms_q <= '0; win_mv_q <= '0; smooth_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) started_q <= 1'b0;
      else if (div_req.start) started_q <= 1'b1;

      if (cfg_i.valid) begin
        if (cfg_i.index <= CfgPt4) pt_q[cfg_i.index] <= cfg_i.data;
        else if (cfg_i.index == CfgNominal) nominal_q <= cfg_i.data[RateW-1:0];
        else if (cfg_i.index == CfgEnable) enable_q <= cfg_i.data[0];
      end

      // rate window update
      if (state_q == StRate && state_d == StMins) begin
        if (win_open || win_close) begin
          win_ms_q <= (now_q == '0) ? TsW'(1) : now_q;
          win_mv_q <= mv_q;
        end
        smooth_q <= enable_q ? (measure ? new_rate : base_rate) : nominal_q;
      end

      if (state_q == StOut && out_free) begin
        ovalid_q    <= 1'b1;
        have_q      <= 1'b1;
        low_q       <= low_n;
        low_cnt_q   <= low_cnt_n;
        norm_cnt_q  <= norm_cnt_n;
        last_raw_q  <= raw_q;
        last_pct_q  <= pct_q;
        last_bars_q <= bars_n;
        last_src_q  <= src_q;
      end else if (ovalid_q && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q <= in_i.raw_code;
      mv_q  <= in_i.sample_mv;
      src_q <= in_i.source_id;
      now_q <= in_i.now_ms;
    end
    if (state_q == StPct) begin
      if (pct_direct) pct_q <= pct_fixed;
      else if (div_done) pct_q <= PctW'({4'b0, seg} * 7'd25 + div_quot[PctW-1:0]);
    end
    if (state_q == StRate && state_d == StMins)
      rate_q <= enable_q ? (measure ? new_rate : base_rate) : nominal_q;
    if (state_q == StMins && state_d == StOut)
      o_mins_q <= div_done ? div_quot[MinsW-1:0] : '0;
    if (state_q == StOut && out_free) begin
      o_pct_q  <= pct_q;
      o_bars_q <= bars_n;
      o_low_q  <= low_n;
      o_rate_q <= rate_q;
      o_chg_q  <= chg_n;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.percent      = o_pct_q;
  assign out_o.bars         = o_bars_q;
  assign out_o.low_flag     = o_low_q;
  assign out_o.rate_out     = o_rate_q;
  assign out_o.minutes_left = o_mins_q;
  assign out_o.changed      = o_chg_q;
endmodule

FILE: rtl/bgm_div.sv
// Restoring divider, one quotient bit per cycle.
module bgm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bgm_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [bgm_pkg::DivNW-1:0] quot_o
);
  import bgm_pkg::*;

  localparam int unsigned CntW = $clog2(DivNW + 1);

  logic [DivNW-1:0] quot_q, quot_d;
  logic [DivDW:0]   rem_q, rem_d;
  logic [DivDW-1:0] den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivDW:0]   trial;
  logic [DivDW:0]   shifted;

  always_comb begin
    shifted = {rem_q[DivDW-1:0], quot_q[DivNW-1]};
    trial   = shifted - {1'b0, den_q};
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CntW'(DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivDW]) begin
        rem_d  = trial;
        quot_d = {quot_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[DivNW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

FILE: rtl/bgm_checker.sv
module bgm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [bgm_pkg::PctW-1:0]  percent,
  input logic [bgm_pkg::BarsW-1:0] bars,
  input logic [bgm_pkg::RateW-1:0] rate_out
);
  import bgm_pkg::*;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> percent <= PctW'(100)) else $error("percent out of range");

  a_bars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (bars == 3'd4) == (percent == PctW'(100))) else $error("bars mismatch");

  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> rate_out <= MaxRate) else $error("rate out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(percent)) else $error("result dropped");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second word taken early");
endmodule

bind battery_gauge_monitor bgm_checker u_bgm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .percent   (out_o.percent),
  .bars      (out_o.bars),
  .rate_out  (out_o.rate_out)
);
